// File: hw/rtl/clu_pkg.sv
// Shared types and constants for the 8-bit load unit.
package clu_pkg;

  localparam int unsigned NUM_REGS = 7;

  localparam logic [2:0] REG_B   = 3'd0;
  localparam logic [2:0] REG_C   = 3'd1;
  localparam logic [2:0] REG_D   = 3'd2;
  localparam logic [2:0] REG_E   = 3'd3;
  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam logic [2:0] SLOT_A = 3'd6;

  localparam logic [7:0] OP_LD_RR_LO   = 8'h40;
  localparam logic [7:0] OP_LD_RR_HI   = 8'h7F;
  localparam logic [7:0] OP_HALT       = 8'h76;
  localparam logic [7:0] OP_LD_BC_A    = 8'h02;
  localparam logic [7:0] OP_LD_DE_A    = 8'h12;
  localparam logic [7:0] OP_LD_HLI_A   = 8'h22;
  localparam logic [7:0] OP_LD_HLD_A   = 8'h32;
  localparam logic [7:0] OP_LD_A_BC    = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE    = 8'h1A;
  localparam logic [7:0] OP_LD_A_HLI   = 8'h2A;
  localparam logic [7:0] OP_LD_A_HLD   = 8'h3A;
  localparam logic [7:0] OP_LDH_N_A    = 8'hE0;
  localparam logic [7:0] OP_LDH_A_N    = 8'hF0;
  localparam logic [7:0] OP_LDH_C_A    = 8'hE2;
  localparam logic [7:0] OP_LDH_A_C    = 8'hF2;
  localparam logic [7:0] OP_LD_NN_A    = 8'hEA;
  localparam logic [7:0] OP_LD_A_NN    = 8'hFA;

  localparam logic [7:0] HIGH_PAGE = 8'hFF;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_MEM,
    SRC_IMM
  } src_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_REG,
    DST_MEM
  } dst_t;

  typedef enum logic [2:0] {
    ADDR_HL,
    ADDR_BC,
    ADDR_DE,
    ADDR_HIGH_C,
    ADDR_CONST
  } addr_t;

  typedef enum logic [1:0] {
    HL_KEEP,
    HL_INC,
    HL_DEC
  } hl_adj_t;

  typedef struct packed {
    logic        handled;
    src_t        src;
    logic [2:0]  src_reg;
    dst_t        dst;
    logic [2:0]  dst_reg;
    addr_t       addr_sel;
    hl_adj_t     hl_adj;
    logic [7:0]  val8;
    logic [15:0] caddr;
  } cmd_t;

  typedef struct packed {
    logic        handled;
    logic [1:0]  bus_op;
    logic [15:0] bus_addr;
    logic [7:0]  bus_wdata;
    logic [7:0]  view_a;
    logic [15:0] view_bc;
    logic [15:0] view_de;
    logic [15:0] view_hl;
  } res_t;

  function automatic logic [2:0] reg_slot(input logic [2:0] r);
    return (r == REG_A) ? SLOT_A : r;
  endfunction

endpackage

// File: hw/rtl/cpu_8bit_load_unit.sv
// Top level of the 8-bit load unit: front decode, command queue, execute stage, result queue.
// A beat goes through the command queue, then the execute stage, into the result queue.
// Throughput: one beat per cycle while the result queue has room, set by the execute stage.
// Both queues let the input and result sides stall independently of each other.
// Reset: rst is synchronous and active high; it empties both queues and clears B,C,D,E,H,L,A.
module cpu_8bit_load_unit #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  opcode,
  input  logic [7:0]  imm_byte,
  input  logic [15:0] imm_word,
  input  logic [7:0]  mem_rdata,
  input  logic [2:0]  reg_sel,
  input  logic [7:0]  reg_value,
  output logic        empty,
  input  logic        pop,
  output logic        handled,
  output logic [1:0]  bus_op,
  output logic [15:0] bus_addr,
  output logic [7:0]  bus_wdata,
  output logic [7:0]  view_a,
  output logic [15:0] view_bc,
  output logic [15:0] view_de,
  output logic [15:0] view_hl
);
  import clu_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  clu_front u_front (
    .req_type  (req_type),
    .opcode    (opcode),
    .imm_byte  (imm_byte),
    .imm_word  (imm_word),
    .mem_rdata (mem_rdata),
    .reg_sel   (reg_sel),
    .reg_value (reg_value),
    .cmd       (cmd_in)
  );

  clu_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  clu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  clu_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign handled   = res_head.handled;
  assign bus_op    = res_head.bus_op;
  assign bus_addr  = res_head.bus_addr;
  assign bus_wdata = res_head.bus_wdata;
  assign view_a    = res_head.view_a;
  assign view_bc   = res_head.view_bc;
  assign view_de   = res_head.view_de;
  assign view_hl   = res_head.view_hl;

`ifndef SYNTHESIS
  a_unhandled_no_bus: assert property (@(posedge clk) disable iff (rst)
    (!empty && !handled) |-> (bus_op == BUS_NONE))
    else $error("Unhandled beat requests a bus access.");

  a_read_no_wdata: assert property (@(posedge clk) disable iff (rst)
    (!empty && bus_op == BUS_READ) |-> (bus_wdata == 8'd0))
    else $error("Read beat carries write data.");

  a_no_bus_no_addr: assert property (@(posedge clk) disable iff (rst)
    (!empty && bus_op == BUS_NONE) |-> (bus_addr == 16'd0 && bus_wdata == 8'd0))
    else $error("Beat without bus access carries an address or data.");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("Queues not empty after reset.");
`endif

endmodule

// File: hw/rtl/clu_front.sv
// Front end: classifies each input beat into a load command.
module clu_front (
  input  logic           req_type,
  input  logic [7:0]     opcode,
  input  logic [7:0]     imm_byte,
  input  logic [15:0]    imm_word,
  input  logic [7:0]     mem_rdata,
  input  logic [2:0]     reg_sel,
  input  logic [7:0]     reg_value,
  output clu_pkg::cmd_t  cmd
);
  import clu_pkg::*;

  logic [2:0] y;
  logic [2:0] z;

  assign y = opcode[5:3];
  assign z = opcode[2:0];

  always_comb begin
    cmd          = '0;
    cmd.handled  = 1'b0;
    cmd.src      = SRC_IMM;
    cmd.src_reg  = REG_A;
    cmd.dst      = DST_NONE;
    cmd.dst_reg  = REG_A;
    cmd.addr_sel = ADDR_HL;
    cmd.hl_adj   = HL_KEEP;
    cmd.val8     = mem_rdata;
    cmd.caddr    = imm_word;
    if (req_type) begin
      cmd.val8    = reg_value;
      cmd.dst_reg = reg_sel;
      cmd.dst     = (reg_sel == REG_MEM) ? DST_NONE : DST_REG;
    end else if (opcode inside {[OP_LD_RR_LO:OP_LD_RR_HI]} && opcode != OP_HALT) begin
      cmd.handled = 1'b1;
      cmd.src     = (z == REG_MEM) ? SRC_MEM : SRC_REG;
      cmd.src_reg = z;
      cmd.dst     = (y == REG_MEM) ? DST_MEM : DST_REG;
      cmd.dst_reg = y;
    end else if (opcode < OP_LD_RR_LO && z == REG_MEM) begin
      cmd.handled = 1'b1;
      cmd.src     = SRC_IMM;
      cmd.val8    = imm_byte;
      cmd.dst     = (y == REG_MEM) ? DST_MEM : DST_REG;
      cmd.dst_reg = y;
    end else begin
      cmd.handled = 1'b1;
      case (opcode)
        OP_LD_BC_A, OP_LD_DE_A, OP_LD_HLI_A, OP_LD_HLD_A,
        OP_LDH_N_A, OP_LDH_C_A, OP_LD_NN_A: begin
          cmd.src = SRC_REG;
          cmd.dst = DST_MEM;
        end
        OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_HLI, OP_LD_A_HLD,
        OP_LDH_A_N, OP_LDH_A_C, OP_LD_A_NN: begin
          cmd.src = SRC_MEM;
          cmd.dst = DST_REG;
        end
        default: begin
          cmd.handled = 1'b0;
        end
      endcase
      case (opcode)
        OP_LD_BC_A, OP_LD_A_BC: cmd.addr_sel = ADDR_BC;
        OP_LD_DE_A, OP_LD_A_DE: cmd.addr_sel = ADDR_DE;
        OP_LDH_C_A, OP_LDH_A_C: cmd.addr_sel = ADDR_HIGH_C;
        OP_LDH_N_A, OP_LDH_A_N: begin
          cmd.addr_sel = ADDR_CONST;
          cmd.caddr    = {HIGH_PAGE, imm_byte};
        end
        OP_LD_NN_A, OP_LD_A_NN: cmd.addr_sel = ADDR_CONST;
        default: cmd.addr_sel = ADDR_HL;
      endcase
      case (opcode)
        OP_LD_HLI_A, OP_LD_A_HLI: cmd.hl_adj = HL_INC;
        OP_LD_HLD_A, OP_LD_A_HLD: cmd.hl_adj = HL_DEC;
        default: cmd.hl_adj = HL_KEEP;
      endcase
    end
  end

endmodule

// File: hw/rtl/clu_fifo.sv
// Small first-in first-out queue of fixed-width beats, at least two entries deep.
module clu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: hw/rtl/clu_back.sv
// Back end: register file; one load command per cycle unless res_full is high.
module clu_back (
  input  logic           clk,
  input  logic           rst,
  input  clu_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output clu_pkg::res_t  res,
  output logic           res_push,
  input  logic           res_full
);
  import clu_pkg::*;

  logic [7:0]  regs      [NUM_REGS];
  logic [7:0]  regs_next [NUM_REGS];
  logic [7:0]  value;
  logic [15:0] hl;
  logic [15:0] hl_new;
  logic [15:0] addr;
  logic        fire;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;
  assign hl       = {regs[REG_H], regs[REG_L]};

  always_comb begin
    regs_next = regs;
    hl_new    = hl;
    case (cmd.src)
      SRC_REG: value = regs[reg_slot(cmd.src_reg)];
      default: value = cmd.val8;
    endcase
    case (cmd.addr_sel)
      ADDR_BC:     addr = {regs[REG_B], regs[REG_C]};
      ADDR_DE:     addr = {regs[REG_D], regs[REG_E]};
      ADDR_HIGH_C: addr = {HIGH_PAGE, regs[REG_C]};
      ADDR_CONST:  addr = cmd.caddr;
      default:     addr = hl;
    endcase
    if (cmd.dst == DST_REG) begin
      regs_next[reg_slot(cmd.dst_reg)] = value;
    end
    case (cmd.hl_adj)
      HL_INC: hl_new = hl + 16'd1;
      HL_DEC: hl_new = hl - 16'd1;
      default: hl_new = hl;
    endcase
    if (cmd.hl_adj != HL_KEEP) begin
      regs_next[REG_H] = hl_new[15:8];
      regs_next[REG_L] = hl_new[7:0];
    end

    res           = '0;
    res.handled   = cmd.handled;
    if (cmd.src == SRC_MEM) begin
      res.bus_op   = BUS_READ;
      res.bus_addr = addr;
    end else if (cmd.dst == DST_MEM) begin
      res.bus_op    = BUS_WRITE;
      res.bus_addr  = addr;
      res.bus_wdata = value;
    end else begin
      res.bus_op = BUS_NONE;
    end
    res.view_a  = regs_next[SLOT_A];
    res.view_bc = {regs_next[REG_B], regs_next[REG_C]};
    res.view_de = {regs_next[REG_D], regs_next[REG_E]};
    res.view_hl = {regs_next[REG_H], regs_next[REG_L]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(NUM_REGS); i++) begin
        regs[3'(i)] <= '0;
      end
    end else if (fire) begin
      regs <= regs_next;
    end
  end

endmodule

// File: tb/sv/cpu_8bit_load_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8-bit load unit with a register-file scoreboard.
module cpu_8bit_load_unit_test;
  import clu_pkg::*;

  localparam logic REQ_EXEC  = 1'b0;
  localparam logic REQ_SETUP = 1'b1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned BEATS_PER_PHASE = 206;

  class load_scoreboard;
    logic [7:0] gpr [8];
    res_t expected_views[$];
    int unsigned errors;
    int unsigned n_setup, n_instr, n_loads, n_reads, n_writes, n_checked;

    function new();
      foreach (gpr[i]) gpr[i] = 8'h00;
      errors = 0;
      n_setup = 0;
      n_instr = 0;
      n_loads = 0;
      n_reads = 0;
      n_writes = 0;
      n_checked = 0;
    endfunction

    function void record_instruction(logic rtype, logic [7:0] op, logic [7:0] imm8,
                                     logic [15:0] imm16, logic [7:0] rdata,
                                     logic [2:0] sel, logic [7:0] value);
      res_t e;
      logic [15:0] hl, hl_next;
      logic [7:0] v;
      logic [2:0] y, z;
      logic simple;
      e = '0;
      v = 8'h00;
      simple = 1'b0;
      y = op[5:3];
      z = op[2:0];
      hl = {gpr[REG_H], gpr[REG_L]};
      hl_next = hl;
      if (rtype == REQ_SETUP) begin
        n_setup++;
        if (sel != REG_MEM) gpr[sel] = value;
      end else begin
        n_instr++;
        e.handled = 1'b1;
        if (op >= OP_LD_RR_LO && op <= OP_LD_RR_HI && op != OP_HALT) begin
          simple = 1'b1;
          if (z == REG_MEM) begin
            e.bus_op = BUS_READ;
            e.bus_addr = hl;
            v = rdata;
          end else begin
            v = gpr[z];
          end
        end else if (op < OP_LD_RR_LO && z == REG_MEM) begin
          simple = 1'b1;
          v = imm8;
        end
        if (simple) begin
          if (y == REG_MEM) begin
            e.bus_op = BUS_WRITE;
            e.bus_addr = hl;
            e.bus_wdata = v;
          end else begin
            gpr[y] = v;
          end
        end else begin
          case (op)
            OP_LD_BC_A, OP_LD_A_BC: e.bus_addr = {gpr[REG_B], gpr[REG_C]};
            OP_LD_DE_A, OP_LD_A_DE: e.bus_addr = {gpr[REG_D], gpr[REG_E]};
            OP_LD_HLI_A, OP_LD_A_HLI: begin
              e.bus_addr = hl;
              hl_next = hl + 16'd1;
            end
            OP_LD_HLD_A, OP_LD_A_HLD: begin
              e.bus_addr = hl;
              hl_next = hl - 16'd1;
            end
            OP_LDH_N_A, OP_LDH_A_N: e.bus_addr = {HIGH_PAGE, imm8};
            OP_LDH_C_A, OP_LDH_A_C: e.bus_addr = {HIGH_PAGE, gpr[REG_C]};
            OP_LD_NN_A, OP_LD_A_NN: e.bus_addr = imm16;
            default: e.handled = 1'b0;
          endcase
          if (e.handled) begin
            case (op)
              OP_LD_BC_A, OP_LD_DE_A, OP_LD_HLI_A, OP_LD_HLD_A,
              OP_LDH_N_A, OP_LDH_C_A, OP_LD_NN_A: begin
                e.bus_op = BUS_WRITE;
                e.bus_wdata = gpr[REG_A];
              end
              default: begin
                e.bus_op = BUS_READ;
                gpr[REG_A] = rdata;
              end
            endcase
          end
          if (hl_next != hl) begin
            gpr[REG_H] = hl_next[15:8];
            gpr[REG_L] = hl_next[7:0];
          end
        end
        if (e.handled) n_loads++;
        if (e.bus_op == BUS_READ) n_reads++;
        if (e.bus_op == BUS_WRITE) n_writes++;
      end
      e.view_a = gpr[REG_A];
      e.view_bc = {gpr[REG_B], gpr[REG_C]};
      e.view_de = {gpr[REG_D], gpr[REG_E]};
      e.view_hl = {gpr[REG_H], gpr[REG_L]};
      expected_views.push_back(e);
    endfunction

    function void check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_bus_view(res_t got);
      res_t e;
      if (expected_views.size() == 0) begin
        $error("result beat arrived with nothing outstanding");
        errors++;
      end else begin
        e = expected_views.pop_front();
        n_checked++;
        check_field("handled", 32'(e.handled), 32'(got.handled));
        check_field("bus_op", 32'(e.bus_op), 32'(got.bus_op));
        check_field("bus_addr", 32'(e.bus_addr), 32'(got.bus_addr));
        check_field("bus_wdata", 32'(e.bus_wdata), 32'(got.bus_wdata));
        check_field("view_a", 32'(e.view_a), 32'(got.view_a));
        check_field("view_bc", 32'(e.view_bc), 32'(got.view_bc));
        check_field("view_de", 32'(e.view_de), 32'(got.view_de));
        check_field("view_hl", 32'(e.view_hl), 32'(got.view_hl));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push, full, empty, pop;
  logic req_type;
  logic [7:0] opcode, imm_byte, mem_rdata, reg_value;
  logic [15:0] imm_word;
  logic [2:0] reg_sel;
  logic handled;
  logic [1:0] bus_op;
  logic [15:0] bus_addr;
  logic [7:0] bus_wdata, view_a;
  logic [15:0] view_bc, view_de, view_hl;

  load_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  cpu_8bit_load_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .opcode(opcode), .imm_byte(imm_byte), .imm_word(imm_word),
    .mem_rdata(mem_rdata), .reg_sel(reg_sel), .reg_value(reg_value),
    .empty(empty), .pop(pop), .handled(handled), .bus_op(bus_op),
    .bus_addr(bus_addr), .bus_wdata(bus_wdata), .view_a(view_a),
    .view_bc(view_bc), .view_de(view_de), .view_hl(view_hl)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic drive_beat(logic rtype, logic [7:0] op, logic [7:0] imm8,
                            logic [15:0] imm16, logic [7:0] rdata,
                            logic [2:0] sel, logic [7:0] value);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rtype;
    opcode <= op;
    imm_byte <= imm8;
    imm_word <= imm16;
    mem_rdata <= rdata;
    reg_sel <= sel;
    reg_value <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.record_instruction(rtype, op, imm8, imm16, rdata, sel, value);
  endtask

  task automatic issue_exec(logic [7:0] op, logic [7:0] imm8, logic [15:0] imm16,
                            logic [7:0] rdata);
    drive_beat(REQ_EXEC, op, imm8, imm16, rdata, 3'($urandom_range(7)), rand_byte());
  endtask

  task automatic issue_setup(logic [2:0] sel, logic [7:0] value);
    drive_beat(REQ_SETUP, rand_byte(), rand_byte(), 16'($urandom), rand_byte(), sel, value);
  endtask

  // Result side: check each popped beat, then pick the pop level for the next edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        sb.check_bus_view({handled, bus_op, bus_addr, bus_wdata,
                           view_a, view_bc, view_de, view_hl});
      if (rst) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic [7:0] op;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    req_type = REQ_EXEC;
    opcode = 8'h00;
    imm_byte = 8'h00;
    imm_word = 16'h0000;
    mem_rdata = 8'h00;
    reg_sel = REG_B;
    reg_value = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: HL wrap both ways, the memory operand, every addressing form.
    issue_setup(REG_A, 8'hFF);
    issue_setup(REG_H, 8'hFF);
    issue_setup(REG_L, 8'hFF);
    issue_setup(REG_MEM, 8'hAA);
    issue_exec(OP_LD_HLI_A, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_LD_HLD_A, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_LD_A_HLI, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_LD_A_HLD, 8'h00, 16'h0000, 8'hFF);
    issue_exec({2'b00, REG_MEM, REG_MEM}, 8'h5A, 16'h0000, 8'h00);
    issue_exec({2'b01, REG_A, REG_MEM}, 8'h00, 16'h0000, 8'hA5);
    issue_exec({2'b00, REG_C, REG_MEM}, 8'hFF, 16'h0000, 8'h00);
    issue_exec(OP_LDH_C_A, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_LDH_A_C, 8'h00, 16'h0000, 8'h3C);
    issue_exec(OP_LDH_N_A, 8'hFF, 16'h0000, 8'h00);
    issue_exec(OP_LDH_A_N, 8'h00, 16'h0000, 8'hC3);
    issue_exec(OP_LD_NN_A, 8'h00, 16'hFFFF, 8'h00);
    issue_exec(OP_LD_A_NN, 8'h00, 16'h0000, 8'h81);
    issue_exec(OP_LD_BC_A, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_LD_A_BC, 8'h00, 16'h0000, 8'h7E);
    issue_exec(OP_LD_DE_A, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_LD_A_DE, 8'h00, 16'h0000, 8'h01);
    issue_exec({2'b01, REG_MEM, REG_B}, 8'h00, 16'h0000, 8'h00);
    issue_exec(OP_HALT, 8'hFF, 16'hFFFF, 8'hFF);
    issue_exec(8'hCB, 8'h00, 16'h0000, 8'h00);
    issue_exec(8'hFF, 8'h00, 16'h0000, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      repeat (BEATS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          issue_setup(3'($urandom_range(7)), rand_byte());
        end else begin
          if (pick < 50) op = OP_LD_RR_LO | 8'($urandom_range(63));
          else if (pick < 65) op = {2'b00, 3'($urandom_range(7)), REG_MEM};
          else if (pick < 90) begin
            case ($urandom_range(13))
              0: op = OP_LD_BC_A;
              1: op = OP_LD_DE_A;
              2: op = OP_LD_HLI_A;
              3: op = OP_LD_HLD_A;
              4: op = OP_LD_A_BC;
              5: op = OP_LD_A_DE;
              6: op = OP_LD_A_HLI;
              7: op = OP_LD_A_HLD;
              8: op = OP_LDH_N_A;
              9: op = OP_LDH_A_N;
              10: op = OP_LDH_C_A;
              11: op = OP_LDH_A_C;
              12: op = OP_LD_NN_A;
              default: op = OP_LD_A_NN;
            endcase
          end else op = 8'($urandom_range(255));
          issue_exec(op, rand_byte(),
                     ($urandom_range(3) == 0) ? {rand_byte(), rand_byte()} : 16'($urandom),
                     rand_byte());
        end
      end
    end
    push <= 1'b0;

    while (sb.expected_views.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d setup writes and %0d instructions (%0d loads: %0d reads, %0d writes)",
             sb.n_setup, sb.n_instr, sb.n_loads, sb.n_reads, sb.n_writes);
    $display("checked %0d result beats under four idle/stall mixes, %0d mismatches",
             sb.n_checked, sb.errors);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/clu_pkg.sv
hw/rtl/clu_front.sv
hw/rtl/clu_fifo.sv
hw/rtl/clu_back.sv
hw/rtl/cpu_8bit_load_unit.sv
tb/sv/cpu_8bit_load_unit_test.sv
